>>> rtl/core/legik_pkg.sv
// Shared types, constants and helpers for the leg inverse kinematics block.
// Used by every module under rtl/core; depends on nothing.
package legik_pkg;

  localparam int CORDIC_STAGES = 18;

  // Datapath widths
  localparam int XY_W   = 44;  // CORDIC x/y, positions scaled to Q.24
  localparam int ANG_W  = 36;  // CORDIC angle accumulator, Q.30 radians
  localparam int MAG_W  = 34;  // final CORDIC x, always non-negative
  localparam int SIDE_W = 56;  // sideband carried along a CORDIC pipe
  localparam int Q_W    = 38;  // angle rounding and saturation
  localparam int ANG_FRAC_DROP = 14;

  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  localparam int DIV_STEPS  = 30;
  localparam int SQRT_STEPS = 31;

  localparam logic signed [ANG_W-1:0] PI_Q30   = 36'sd3373259426;
  localparam logic [29:0]             GAIN_Q30 = 30'd652032874;
  localparam logic [30:0]             ONE_Q30  = 31'h4000_0000;
  localparam logic [61:0]             SQ_ONE   = 62'h1 << 60;

  localparam logic signed [Q_W-1:0] YAW_MAX  = 38'sd205887;
  localparam logic signed [Q_W-1:0] HIP_MAX  = 38'sd411774;
  localparam logic signed [Q_W-1:0] KNEE_MAX = 38'sd205887;

  // Configuration register indexes
  localparam logic [1:0] CFG_HIP_OFFSET   = 2'd0;
  localparam logic [1:0] CFG_THIGH_LENGTH = 2'd1;
  localparam logic [1:0] CFG_SHANK_LENGTH = 2'd2;

  // atan(2^-i) in Q.30, truncated for i up to 26 and rounded above that
  localparam logic [29:0] ATAN_TAB [32] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
    30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
    30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
    30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
    30'h00000001, 30'h00000000
  };

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } target_t;

  typedef struct packed {
    logic [22:0] hip_offset;
    logic [22:0] thigh_length;
    logic [22:0] shank_length;
  } cfg_t;

  typedef struct packed {
    logic signed [18:0] yaw;
    logic signed [19:0] hip;
    logic [17:0]        knee;
    logic               unreach;
  } result_t;

  typedef struct packed {
    logic                    neg;
    logic                    done;
    logic                    denz;
    logic                    unreach;
    logic signed [ANG_W-1:0] pitch;
    logic signed [18:0]      yaw;
  } div_side_t;

  // Round Q.30 to Q.16 (toward minus infinity after adding half) and clamp
  function automatic logic signed [Q_W-1:0] angle_q16(input logic signed [Q_W-1:0] v,
                                                      input logic signed [Q_W-1:0] lo,
                                                      input logic signed [Q_W-1:0] hi);
    logic signed [Q_W-1:0] t;
    t = (v + 38'sd8192) >>> ANG_FRAC_DROP;
    if (t < lo) begin
      return lo;
    end else if (t > hi) begin
      return hi;
    end
    return t;
  endfunction

endpackage

>>> rtl/core/three_joint_leg_inverse_kinematics.sv
// Top level of the three-joint leg inverse kinematics block.
// Uses legik_pkg, legik_fifo (front queue) and legik_back (compute pipe).
//
// Usage:
//   Input channel: drive in_target_x/y/z (signed Q8.16 m) and raise push;
//   the target is taken on a rising edge with push high and full low.
//   Result channel: while empty is low, out_yaw_angle (Q3.16 rad),
//   out_hip_angle (Q4.16 rad), out_knee_angle (unsigned Q2.16 rad) and
//   out_unreachable hold the oldest result; raise pop to take it on that edge.
//   Configuration: cfg_valid with cfg_index (0 hip offset, 1 thigh length,
//   2 shank length) and cfg_wdata; cfg_ready is always high and index 3 is
//   dropped. Write only while no item is in flight.
// Timing:
//   One item per cycle sustained while results are popped. With no stall the
//   result passes, after the edge that took the target, through three CORDIC
//   pipes in series (yaw, pitch, then correction with the knee one beside it),
//   the divider, the square root, seven multiply and register stages and the
//   output register. The queue's read data is combinational.
// Reset: rst_n low clears the queue, every stage valid and the output valid
//   flag, and loads the link lengths to their defaults.
// Stall: when the result is not popped the whole compute pipe holds; the
//   four-entry input queue keeps taking targets until it fills.
module three_joint_leg_inverse_kinematics (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [23:0] in_target_x,
  input  logic signed [23:0] in_target_y,
  input  logic signed [23:0] in_target_z,
  output logic               empty,
  input  logic               pop,
  output logic signed [18:0] out_yaw_angle,
  output logic signed [19:0] out_hip_angle,
  output logic [17:0]        out_knee_angle,
  output logic               out_unreachable,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [22:0]        cfg_wdata
);

  legik_pkg::cfg_t     cfg_r;
  legik_pkg::target_t  in_item, q_item;
  legik_pkg::result_t  back_res, out_res_r;
  logic                q_empty, q_pop, en, back_v, out_v_r;

  // Configuration registers: always ready, unknown index dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hip_offset   <= 23'd0;
      cfg_r.thigh_length <= 23'd65536;
      cfg_r.shank_length <= 23'd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        legik_pkg::CFG_HIP_OFFSET:   cfg_r.hip_offset   <= cfg_wdata;
        legik_pkg::CFG_THIGH_LENGTH: cfg_r.thigh_length <= cfg_wdata;
        legik_pkg::CFG_SHANK_LENGTH: cfg_r.shank_length <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front: queue targets
  assign in_item.x = in_target_x;
  assign in_item.y = in_target_y;
  assign in_item.z = in_target_z;

  // Advance the pipe whenever the output slot is free or being drained
  assign en    = !out_v_r || pop;
  assign q_pop = en && !q_empty;

  legik_fifo u_fifo (
    .clk, .rst_n,
    .push,
    .full,
    .wr_data(in_item),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_data(q_item)
  );

  legik_back u_back (
    .clk, .rst_n, .en,
    .in_v   (!q_empty),
    .in_data(q_item),
    .cfg    (cfg_r),
    .out_v  (back_v),
    .out_res(back_res)
  );

  // Output register: hold the result until popped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= back_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r <= back_res;
    end
  end

  assign empty           = !out_v_r;
  assign out_yaw_angle   = out_res_r.yaw;
  assign out_hip_angle   = out_res_r.hip;
  assign out_knee_angle  = out_res_r.knee;
  assign out_unreachable = out_res_r.unreach;

endmodule

>>> rtl/core/legik_fifo.sv
// Input queue of foot targets between the accept side and the compute pipe.
// Uses legik_pkg for the target item type.
module legik_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  legik_pkg::target_t  wr_data,
  input  logic                pop,
  output logic                empty,
  output legik_pkg::target_t  rd_data
);

  legik_pkg::target_t               mem_r [legik_pkg::FIFO_DEPTH];
  logic [legik_pkg::FIFO_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [legik_pkg::FIFO_AW:0]      count_r, count_nxt;
  logic                             do_push, do_pop;

  assign full    = (count_r == (legik_pkg::FIFO_AW+1)'(legik_pkg::FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/core/legik_cordic.sv
// Pipelined vectoring CORDIC: angle (Q.30) and unscaled magnitude of (x, y).
// One pre-rotation stage plus CORDIC_STAGES micro-rotations; uses legik_pkg.
module legik_cordic (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_v,
  input  logic signed [legik_pkg::XY_W-1:0]      in_x,
  input  logic signed [legik_pkg::XY_W-1:0]      in_y,
  input  logic [legik_pkg::SIDE_W-1:0]           in_side,
  output logic                                   out_v,
  output logic signed [legik_pkg::ANG_W-1:0]     out_ang,
  output logic signed [legik_pkg::XY_W-1:0]      out_x,
  output logic [legik_pkg::SIDE_W-1:0]           out_side
);

  localparam int N = legik_pkg::CORDIC_STAGES;

  logic                                v_r    [N+1];
  logic                                zero_r [N+1];
  logic signed [legik_pkg::XY_W-1:0]   x_r    [N+1];
  logic signed [legik_pkg::XY_W-1:0]   y_r    [N+1];
  logic signed [legik_pkg::ANG_W-1:0]  a_r    [N+1];
  logic [legik_pkg::SIDE_W-1:0]        s_r    [N+1];

  // Turn a left-half-plane vector by pi so the micro-rotations converge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (in_x == '0) && (in_y == '0);
      s_r[0]    <= in_side;
      if (in_x < 0) begin
        x_r[0] <= -in_x;
        y_r[0] <= -in_y;
        a_r[0] <= (in_y >= 0) ? legik_pkg::PI_Q30 : -legik_pkg::PI_Q30;
      end else begin
        x_r[0] <= in_x;
        y_r[0] <= in_y;
        a_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [legik_pkg::XY_W-1:0]  sx, sy;
    logic signed [legik_pkg::ANG_W-1:0] da;

    assign sx = y_r[i] >>> i;
    assign sy = x_r[i] >>> i;
    assign da = {{(legik_pkg::ANG_W-30){1'b0}}, legik_pkg::ATAN_TAB[i]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        s_r[i+1]    <= s_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + sx;
          y_r[i+1] <= y_r[i] - sy;
          a_r[i+1] <= a_r[i] + da;
        end else begin
          x_r[i+1] <= x_r[i] - sx;
          y_r[i+1] <= y_r[i] + sy;
          a_r[i+1] <= a_r[i] - da;
        end
      end
    end
  end

  // A zero vector has angle 0 and magnitude 0
  assign out_v    = v_r[N];
  assign out_ang  = zero_r[N] ? '0 : a_r[N];
  assign out_x    = zero_r[N] ? '0 : x_r[N];
  assign out_side = s_r[N];

endmodule

>>> rtl/core/legik_back.sv
// Compute pipe: yaw and pitch CORDICs, law-of-cosines divider, square root,
// knee and correction CORDICs. Uses legik_pkg and legik_cordic.
module legik_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_v,
  input  legik_pkg::target_t    in_data,
  input  legik_pkg::cfg_t       cfg,
  output logic                  out_v,
  output legik_pkg::result_t    out_res
);

  localparam int XW = legik_pkg::XY_W;
  localparam int AW = legik_pkg::ANG_W;
  localparam int MW = legik_pkg::MAG_W;
  localparam int SW = legik_pkg::SIDE_W;
  localparam int QW = legik_pkg::Q_W;
  localparam int DN = legik_pkg::DIV_STEPS;
  localparam int SN = legik_pkg::SQRT_STEPS;

  // ---------------- yaw CORDIC on (x, y)
  logic signed [XW-1:0] c1_xi, c1_yi, c1_xo;
  logic signed [AW-1:0] c1_ang;
  logic [SW-1:0]        c1_side;
  logic                 c1_v;

  assign c1_xi = {{(XW-32){in_data.x[23]}}, in_data.x, 8'h00};
  assign c1_yi = {{(XW-32){in_data.y[23]}}, in_data.y, 8'h00};

  legik_cordic u_cordic_yaw (
    .clk, .rst_n, .en,
    .in_v    (in_v),
    .in_x    (c1_xi),
    .in_y    (c1_yi),
    .in_side ({{(SW-24){1'b0}}, in_data.z}),
    .out_v   (c1_v),
    .out_ang (c1_ang),
    .out_x   (c1_xo),
    .out_side(c1_side)
  );

  // ---------------- radial magnitude, yaw to output format
  logic               b_v_r;
  logic [63:0]        b_prod_r;
  logic signed [18:0] b_yaw_r;
  logic signed [23:0] b_z_r;
  logic signed [QW-1:0] b_yaw_q;

  assign b_yaw_q = legik_pkg::angle_q16({{(QW-AW){c1_ang[AW-1]}}, c1_ang},
                                        -legik_pkg::YAW_MAX, legik_pkg::YAW_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= c1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_prod_r <= 64'(c1_xo[MW-1:0]) * 64'(legik_pkg::GAIN_Q30);
      b_yaw_r  <= b_yaw_q[18:0];
      b_z_r    <= c1_side[23:0];
    end
  end

  // ---------------- pitch CORDIC on (radial - hip offset, -z)
  logic signed [XW-1:0] c2_xi, c2_yi, c2_zx, c2_xo;
  logic signed [AW-1:0] c2_ang;
  logic [SW-1:0]        c2_side;
  logic                 c2_v;

  assign c2_xi = {{(XW-MW){1'b0}}, b_prod_r[63:30]}
               - {{(XW-31){1'b0}}, cfg.hip_offset, 8'h00};
  assign c2_zx = {{(XW-32){b_z_r[23]}}, b_z_r, 8'h00};
  assign c2_yi = -c2_zx;

  legik_cordic u_cordic_pitch (
    .clk, .rst_n, .en,
    .in_v    (b_v_r),
    .in_x    (c2_xi),
    .in_y    (c2_yi),
    .in_side ({{(SW-19){1'b0}}, b_yaw_r}),
    .out_v   (c2_v),
    .out_ang (c2_ang),
    .out_x   (c2_xo),
    .out_side(c2_side)
  );

  // ---------------- reach w, then squares
  logic               d_v_r, e_v_r, f_v_r;
  logic [63:0]        d_prod_r;
  logic signed [AW-1:0] d_pitch_r, e_pitch_r, f_pitch_r;
  logic signed [18:0] d_yaw_r, e_yaw_r, f_yaw_r;
  logic [26:0]        e_wq_r;
  logic [34:0]        e_wsum;
  logic [53:0]        f_w2_r;
  logic [45:0]        f_t2_r, f_s2_r, f_ts_r;

  assign e_wsum = {1'b0, d_prod_r[63:30]} + 35'd128;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
    end else if (en) begin
      d_v_r <= c2_v;
      e_v_r <= d_v_r;
      f_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_prod_r  <= 64'(c2_xo[MW-1:0]) * 64'(legik_pkg::GAIN_Q30);
      d_pitch_r <= c2_ang;
      d_yaw_r   <= c2_side[18:0];
      e_wq_r    <= e_wsum[34:8];
      e_pitch_r <= d_pitch_r;
      e_yaw_r   <= d_yaw_r;
      f_w2_r    <= 54'(e_wq_r) * 54'(e_wq_r);
      f_t2_r    <= 46'(cfg.thigh_length) * 46'(cfg.thigh_length);
      f_s2_r    <= 46'(cfg.shank_length) * 46'(cfg.shank_length);
      f_ts_r    <= 46'(cfg.thigh_length) * 46'(cfg.shank_length);
      f_pitch_r <= e_pitch_r;
      f_yaw_r   <= e_yaw_r;
    end
  end

  // ---------------- cosine of the knee: restoring division, one bit per stage
  logic signed [55:0] g_num;
  logic [55:0]        g_mag;
  logic [46:0]        g_den;
  logic               g_neg, g_denz, g_done, g_unr;

  assign g_num  = 56'(f_w2_r) - 56'(f_t2_r) - 56'(f_s2_r);
  assign g_neg  = g_num[55];
  assign g_mag  = g_neg ? -g_num : g_num;
  assign g_den  = {f_ts_r, 1'b0};
  assign g_denz = (g_den == '0);
  assign g_done = g_denz || (g_mag >= 56'(g_den));
  assign g_unr  = g_denz || (g_mag > 56'(g_den));

  logic                  dv_r   [DN+1];
  logic [46:0]           rem_r  [DN+1];
  logic [46:0]           den_r  [DN+1];
  logic [29:0]           q_r    [DN+1];
  legik_pkg::div_side_t  dside_r[DN+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]         <= g_done ? '0 : g_mag[46:0];
      den_r[0]         <= g_den;
      q_r[0]           <= '0;
      dside_r[0].neg   <= g_neg;
      dside_r[0].done  <= g_done;
      dside_r[0].denz  <= g_denz;
      dside_r[0].unreach <= g_unr;
      dside_r[0].pitch <= f_pitch_r;
      dside_r[0].yaw   <= f_yaw_r;
    end
  end

  for (genvar k = 0; k < DN; k++) begin : g_div
    logic [47:0] rem2, diff;
    logic        ge;

    assign rem2 = {rem_r[k], 1'b0};
    assign ge   = (rem2 >= {1'b0, den_r[k]});
    assign diff = rem2 - {1'b0, den_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]   <= ge ? diff[46:0] : rem2[46:0];
        den_r[k+1]   <= den_r[k];
        q_r[k+1]     <= {q_r[k][28:0], ge};
        dside_r[k+1] <= dside_r[k];
      end
    end
  end

  // ---------------- signed cosine, then its square
  logic [30:0]           h_qm;
  logic signed [31:0]    h_cq, h_cq_r, i_cq_r;
  logic [30:0]           h_cmag;
  logic [61:0]           i_c2_r;
  logic                  h_v_r, i_v_r;
  legik_pkg::div_side_t  h_side_r, i_side_r;

  // a zero denominator forces +1 whatever the sign of the numerator
  assign h_qm   = dside_r[DN].done ? legik_pkg::ONE_Q30 : {1'b0, q_r[DN]};
  assign h_cq   = (dside_r[DN].neg && !dside_r[DN].denz) ? -$signed({1'b0, h_qm})
                                                          : $signed({1'b0, h_qm});
  assign h_cmag = h_cq_r[31] ? 31'(-h_cq_r) : h_cq_r[30:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
      i_v_r <= 1'b0;
    end else if (en) begin
      h_v_r <= dv_r[DN];
      i_v_r <= h_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_cq_r   <= h_cq;
      h_side_r <= dside_r[DN];
      i_c2_r   <= 62'(h_cmag) * 62'(h_cmag);
      i_cq_r   <= h_cq_r;
      i_side_r <= h_side_r;
    end
  end

  // ---------------- sine of the knee: digit-by-digit square root
  logic                  sv_r   [SN+1];
  logic [61:0]           st_r   [SN+1];
  logic [61:0]           sr_r   [SN+1];
  logic signed [31:0]    scq_r  [SN+1];
  legik_pkg::div_side_t  sside_r[SN+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (en) begin
      sv_r[0] <= i_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]    <= legik_pkg::SQ_ONE - i_c2_r;
      sr_r[0]    <= '0;
      scq_r[0]   <= i_cq_r;
      sside_r[0] <= i_side_r;
    end
  end

  for (genvar j = 0; j < SN; j++) begin : g_sqrt
    localparam logic [61:0] BITV = 62'h1 << (60 - 2*j);
    logic [61:0] trial;
    logic        ge;

    assign trial = sr_r[j] + BITV;
    assign ge    = (st_r[j] >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[j+1] <= 1'b0;
      end else if (en) begin
        sv_r[j+1] <= sv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[j+1]    <= ge ? (st_r[j] - trial) : st_r[j];
        sr_r[j+1]    <= ge ? ((sr_r[j] >> 1) + BITV) : (sr_r[j] >> 1);
        scq_r[j+1]   <= scq_r[j];
        sside_r[j+1] <= sside_r[j];
      end
    end
  end

  // ---------------- shank projections
  logic                  k_v_r;
  logic [30:0]           k_sq_r;
  logic signed [31:0]    k_cq_r;
  logic signed [55:0]    k_sc_r, k_sc_sh;
  logic [53:0]           k_ss_r;
  legik_pkg::div_side_t  k_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_v_r <= 1'b0;
    end else if (en) begin
      k_v_r <= sv_r[SN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_sq_r   <= sr_r[SN][30:0];
      k_cq_r   <= scq_r[SN];
      k_sc_r   <= 56'($signed({1'b0, cfg.shank_length})) * 56'(scq_r[SN]);
      k_ss_r   <= 54'(cfg.shank_length) * 54'(sr_r[SN][30:0]);
      k_side_r <= sside_r[SN];
    end
  end

  // ---------------- knee and correction CORDICs, run side by side
  logic signed [XW-1:0] c3_xi, c3_yi, c4_xi, c4_yi;
  logic signed [AW-1:0] c3_ang, c4_ang;
  logic [SW-1:0]        c4_side;
  logic                 c4_v;

  assign k_sc_sh = k_sc_r >>> 22;
  assign c3_xi   = {{(XW-32){k_cq_r[31]}}, k_cq_r};
  assign c3_yi   = {{(XW-31){1'b0}}, k_sq_r};
  assign c4_xi   = {{(XW-31){1'b0}}, cfg.thigh_length, 8'h00} + k_sc_sh[XW-1:0];
  assign c4_yi   = {{(XW-32){1'b0}}, k_ss_r[53:22]};

  legik_cordic u_cordic_knee (
    .clk, .rst_n, .en,
    .in_v    (k_v_r),
    .in_x    (c3_xi),
    .in_y    (c3_yi),
    .in_side ('0),
    .out_v   (),
    .out_ang (c3_ang),
    .out_x   (),
    .out_side()
  );

  legik_cordic u_cordic_corr (
    .clk, .rst_n, .en,
    .in_v    (k_v_r),
    .in_x    (c4_xi),
    .in_y    (c4_yi),
    .in_side ({k_side_r.pitch, k_side_r.yaw, k_side_r.unreach}),
    .out_v   (c4_v),
    .out_ang (c4_ang),
    .out_x   (),
    .out_side(c4_side)
  );

  // ---------------- final angles
  logic signed [AW-1:0] o_pitch;
  logic signed [QW-1:0] o_hip30, o_hip_q, o_knee_q;

  assign o_pitch  = c4_side[SW-1 -: AW];
  assign o_hip30  = {{(QW-AW){o_pitch[AW-1]}}, o_pitch}
                  - {{(QW-AW){c4_ang[AW-1]}}, c4_ang};
  assign o_hip_q  = legik_pkg::angle_q16(o_hip30, -legik_pkg::HIP_MAX, legik_pkg::HIP_MAX);
  assign o_knee_q = legik_pkg::angle_q16({{(QW-AW){c3_ang[AW-1]}}, c3_ang},
                                         '0, legik_pkg::KNEE_MAX);

  assign out_v           = c4_v;
  assign out_res.yaw     = c4_side[19:1];
  assign out_res.hip     = o_hip_q[19:0];
  assign out_res.knee    = o_knee_q[17:0];
  assign out_res.unreach = c4_side[0];

endmodule
